### rtl/core/skt_pkg.sv
// Shared types, widths and codes of the sorted key table.
package skt_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int ACTION_W  = 2;
    localparam int KEY_W     = 17;
    localparam int DEP_W     = 31;
    localparam int PIN_W     = 48;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 6;
    localparam int CNT_OUT_W = 7;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DUP     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [DEP_W-1:0] deposit;
        logic [PIN_W-1:0] pin;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [POS_W-1:0]     position;
        logic [DEP_W-1:0]     found_deposit;
        logic [PIN_W-1:0]     found_pin;
        logic [CNT_OUT_W-1:0] entry_count;
    } result_t;

endpackage

### rtl/core/skt_ram.sv
// Record memory: one write port and one read port with registered read data.
module skt_ram #(
    parameter int DEPTH  = skt_pkg::CAPACITY_DEF,
    parameter int DATA_W = skt_pkg::REC_W
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/skt_seq.sv
// Request sequencer: scans the record memory, shifts entries and writes records.
module skt_seq #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [skt_pkg::ACTION_W-1:0]     in_action,
    input  logic [skt_pkg::KEY_W-1:0]        in_key,
    input  logic [skt_pkg::DEP_W-1:0]        in_deposit,
    input  logic [skt_pkg::PIN_W-1:0]        in_pin,
    output logic                             res_valid,
    input  logic                             res_ready,
    output skt_pkg::result_t                 res,
    output logic                             ram_rd_en,
    output logic [$clog2(CAPACITY)-1:0]      ram_rd_addr,
    input  logic [skt_pkg::REC_W-1:0]        ram_rd_data,
    output logic                             ram_wr_en,
    output logic [$clog2(CAPACITY)-1:0]      ram_wr_addr,
    output logic [skt_pkg::REC_W-1:0]        ram_wr_data
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int OCNT_W = skt_pkg::CNT_OUT_W;
    localparam int OPOS_W = skt_pkg::POS_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]                      state_reg, state_next;
    logic [CNT_W-1:0]                used_reg, used_next;
    logic [skt_pkg::ACTION_W-1:0]    op_reg, op_next;
    logic [skt_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [skt_pkg::DEP_W-1:0]       dep_reg, dep_next;
    logic [skt_pkg::PIN_W-1:0]       pin_reg, pin_next;
    logic [CNT_W-1:0]                scan_reg, scan_next;
    logic [IDX_W-1:0]                cmp_reg, cmp_next;
    logic                            pend_reg, pend_next;
    logic                            issue_reg, issue_next;
    logic [IDX_W-1:0]                slot_reg, slot_next;
    skt_pkg::result_t                res_reg, res_next;
    skt_pkg::rec_t                   rd_rec;

    assign rd_rec    = skt_pkg::rec_t'(ram_rd_data);
    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        dep_next    = dep_reg;
        pin_next    = pin_reg;
        scan_next   = scan_reg;
        cmp_next    = cmp_reg;
        pend_next   = pend_reg;
        issue_next  = issue_reg;
        slot_next   = slot_reg;
        res_next    = res_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = scan_reg[IDX_W-1:0];
        ram_wr_en   = 1'b0;
        ram_wr_addr = slot_reg;
        ram_wr_data = {key_reg, dep_reg, pin_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = in_action;
                    key_next  = in_key;
                    dep_next  = in_deposit;
                    pin_next  = in_pin;
                    scan_next = '0;
                    pend_next = 1'b0;
                    res_next  = '0;
                    res_next.entry_count = OCNT_W'(used_reg);
                    case (in_action)
                        skt_pkg::ACT_CLEAR:
                        begin
                            used_next            = '0;
                            res_next.entry_count = '0;
                            state_next           = ST_DONE;
                        end
                        skt_pkg::ACT_INSERT:
                        begin
                            if (used_reg == CNT_W'(CAPACITY))
                            begin
                                res_next.status = skt_pkg::STAT_FULL;
                                state_next      = ST_DONE;
                            end
                            else if (used_reg == '0)
                            begin
                                slot_next  = '0;
                                state_next = ST_WRITE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        skt_pkg::ACT_LOOKUP:
                        begin
                            if (used_reg == '0)
                            begin
                                res_next.status = skt_pkg::STAT_MISSING;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Reads go out one per cycle; each comparison sees the entry read in the previous cycle.
                if (scan_reg < used_reg)
                begin
                    ram_rd_en = 1'b1;
                    scan_next = scan_reg + CNT_W'(1);
                    cmp_next  = scan_reg[IDX_W-1:0];
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (rd_rec.key >= key_reg)
                    begin
                        pend_next = 1'b0;
                        if (rd_rec.key == key_reg)
                        begin
                            res_next.position = OPOS_W'(cmp_reg);
                            if (op_reg == skt_pkg::ACT_INSERT)
                            begin
                                res_next.status = skt_pkg::STAT_DUP;
                            end
                            else
                            begin
                                res_next.found_deposit = rd_rec.deposit;
                                res_next.found_pin     = rd_rec.pin;
                            end
                            state_next = ST_DONE;
                        end
                        else if (op_reg == skt_pkg::ACT_INSERT)
                        begin
                            slot_next  = cmp_reg;
                            scan_next  = used_reg - CNT_W'(1);
                            issue_next = 1'b1;
                            state_next = ST_SHIFT;
                        end
                        else
                        begin
                            res_next.status = skt_pkg::STAT_MISSING;
                            state_next      = ST_DONE;
                        end
                    end
                    else if (CNT_W'(cmp_reg) == used_reg - CNT_W'(1))
                    begin
                        pend_next = 1'b0;
                        if (op_reg == skt_pkg::ACT_INSERT)
                        begin
                            slot_next  = used_reg[IDX_W-1:0];
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            res_next.status = skt_pkg::STAT_MISSING;
                            state_next      = ST_DONE;
                        end
                    end
                end
            end

            ST_SHIFT:
            begin
                // Read entry j while entry j+2 is written with what was read before.
                if (issue_reg)
                begin
                    ram_rd_en = 1'b1;
                    cmp_next  = scan_reg[IDX_W-1:0];
                    pend_next = 1'b1;
                    if (scan_reg[IDX_W-1:0] == slot_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_next = scan_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = cmp_reg + IDX_W'(1);
                    ram_wr_data = ram_rd_data;
                    if (cmp_reg == slot_reg)
                    begin
                        pend_next  = 1'b0;
                        state_next = ST_WRITE;
                    end
                end
            end

            ST_WRITE:
            begin
                ram_wr_en            = 1'b1;
                used_next            = used_reg + CNT_W'(1);
                res_next.position    = OPOS_W'(slot_reg);
                res_next.entry_count = OCNT_W'(used_reg + CNT_W'(1));
                state_next           = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            pend_reg  <= 1'b0;
            issue_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            pend_reg  <= pend_next;
            issue_reg <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        dep_reg  <= dep_next;
        pin_reg  <= pin_next;
        scan_reg <= scan_next;
        cmp_reg  <= cmp_next;
        slot_reg <= slot_next;
        res_reg  <= res_next;
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(CAPACITY))
        else $error("record count exceeds capacity");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == ST_SHIFT || state_reg == ST_WRITE))
        else $error("memory written outside shift or write phase");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_action == skt_pkg::ACT_CLEAR) |=> used_reg == '0)
        else $error("clear did not empty the table");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> used_reg == $past(used_reg) + CNT_W'(1))
        else $error("insert did not add exactly one record");

endmodule

### rtl/core/sorted_key_table_core.sv
// Top level of the sorted key table: sequencer, record memory and result register.
//
// The table keeps up to CAPACITY records (key, deposit, PIN) in ascending key order.
// Requests arrive as items on the input channel (in_valid/in_ready) with fields
// action, key, deposit and pin_value; action selects clear, insert or lookup.
// Every request gives exactly one result item on the output channel
// (out_valid/out_ready) with status, position, found_deposit, found_pin and
// entry_count.
// A clear goes straight to the done state and hands its result to the output register.
// A lookup or a duplicate insert scans one entry per cycle through the memory read
// port. A successful insert into a table scans up to its slot and shifts every
// later entry up a slot, through the same single memory read port that serves
// the scan. One request is in work at a time, and the sequencer turns ready for
// the next one as the result register is loaded.
// The result register parts the two channels: a new request is accepted while
// an earlier result still waits for out_ready. When the receiver stalls, the
// sequencer holds its finished result until the register is free.
// Reset empties the table and clears the state, flags and output valid; record
// memory contents are not cleared and only slots below the record count are ever read.
module sorted_key_table_core #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [skt_pkg::ACTION_W-1:0]      action,
    input  logic [skt_pkg::KEY_W-1:0]         key,
    input  logic [skt_pkg::DEP_W-1:0]         deposit,
    input  logic [skt_pkg::PIN_W-1:0]         pin_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [skt_pkg::STATUS_W-1:0]      status,
    output logic [skt_pkg::POS_W-1:0]         position,
    output logic [skt_pkg::DEP_W-1:0]         found_deposit,
    output logic [skt_pkg::PIN_W-1:0]         found_pin,
    output logic [skt_pkg::CNT_OUT_W-1:0]     entry_count
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic                        res_valid;
    logic                        res_ready;
    skt_pkg::result_t            res;
    logic                        ram_rd_en;
    logic [IDX_W-1:0]            ram_rd_addr;
    logic [skt_pkg::REC_W-1:0]   ram_rd_data;
    logic                        ram_wr_en;
    logic [IDX_W-1:0]            ram_wr_addr;
    logic [skt_pkg::REC_W-1:0]   ram_wr_data;

    logic                        out_valid_reg, out_valid_next;
    skt_pkg::result_t            out_reg, out_next;

    skt_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_action   (action),
        .in_key      (key),
        .in_deposit  (deposit),
        .in_pin      (pin_value),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data)
    );

    skt_ram #(
        .DEPTH  (CAPACITY),
        .DATA_W (skt_pkg::REC_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    // The result register takes a new item when it is empty or being drained.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign position      = out_reg.position;
    assign found_deposit = out_reg.found_deposit;
    assign found_pin     = out_reg.found_pin;
    assign entry_count   = out_reg.entry_count;

endmodule

### tb/tb_sorted_key_table_core.sv
// Self-checking testbench for the sorted key table core: clear, insert and lookup traffic.
`timescale 1ns / 100ps

module tb_sorted_key_table_core;

    // The table depth matches the default of the block, so the predictor
    // keeps the same number of slots as the record memory.
    localparam int TABLE_DEPTH = skt_pkg::CAPACITY_DEF;

    // The action code that the block answers without changing the table.
    localparam logic [skt_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

    // About this many random items follow the directed opening.
    localparam int RANDOM_ITEMS = 550;

    // A successful insert at the front of a nearly full table shifts nearly every
    // entry, and a receiver that idles 70 percent of the time adds short random
    // stalls on top. The watchdog limit leaves a wide margin over the slowest item.
    localparam int STALL_LIMIT = 40 * (TABLE_DEPTH + 4);

    // Cycles to keep watching the output once nothing is expected any more,
    // so that a stray late result is still caught.
    localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 10;

    localparam int MAX_REPORTS = 10;

    // One request waiting to be driven. A set hold bit makes the driver wait
    // until every earlier result has come back before it offers the item.
    typedef struct {
        logic [skt_pkg::ACTION_W-1:0] act;
        logic [skt_pkg::KEY_W-1:0]    acct;
        logic [skt_pkg::DEP_W-1:0]    dep;
        logic [skt_pkg::PIN_W-1:0]    pin;
        bit                           hold;
    } request_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [skt_pkg::ACTION_W-1:0]  action = skt_pkg::ACT_CLEAR;
    logic [skt_pkg::KEY_W-1:0]     key = '0;
    logic [skt_pkg::DEP_W-1:0]     deposit = '0;
    logic [skt_pkg::PIN_W-1:0]     pin_value = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [skt_pkg::STATUS_W-1:0]  status;
    logic [skt_pkg::POS_W-1:0]     position;
    logic [skt_pkg::DEP_W-1:0]     found_deposit;
    logic [skt_pkg::PIN_W-1:0]     found_pin;
    logic [skt_pkg::CNT_OUT_W-1:0] entry_count;

    // Requests still to be driven, and the results owed by the block for
    // requests it has already taken, oldest first.
    request_t          req_q[$];
    skt_pkg::result_t  owed_q[$];

    // Predicted contents of the table. Only slots below table_count are
    // ever read, matching the block, which leaves its memory uncleared.
    logic [skt_pkg::KEY_W-1:0] table_keys [TABLE_DEPTH];
    logic [skt_pkg::DEP_W-1:0] table_deps [TABLE_DEPTH];
    logic [skt_pkg::PIN_W-1:0] table_pins [TABLE_DEPTH];
    int                        table_count = 0;

    // Keys the stimulus believes are in the table since the last clear. It
    // steers lookups and duplicate inserts toward hits; the predictor alone
    // decides what the block must answer.
    logic [skt_pkg::KEY_W-1:0] live_keys[$];
    bit                        hold_next = 1'b0;

    int  n_sent = 0;
    int  n_recv = 0;
    int  stim_total = 1;
    int  fail_count = 0;
    int  stall_cycles = 0;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  timed_out = 1'b0;

    sorted_key_table_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .key           (key),
        .deposit       (deposit),
        .pin_value     (pin_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .position      (position),
        .found_deposit (found_deposit),
        .found_pin     (found_pin),
        .entry_count   (entry_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Applies one request to the predicted table and returns the result the
    // block has to give for it.
    function automatic skt_pkg::result_t predict_request(
        input logic [skt_pkg::ACTION_W-1:0] act,
        input logic [skt_pkg::KEY_W-1:0]    acct,
        input logic [skt_pkg::DEP_W-1:0]    dep,
        input logic [skt_pkg::PIN_W-1:0]    pin
    );
        skt_pkg::result_t r;
        int               hit;
        int               slot;
        r   = '0;
        hit = -1;
        case (act)
            skt_pkg::ACT_CLEAR:
            begin
                table_count = 0;
            end
            skt_pkg::ACT_INSERT:
            begin
                // A full table is reported even when the key is a duplicate.
                if (table_count >= TABLE_DEPTH)
                begin
                    r.status = skt_pkg::STAT_FULL;
                end
                else
                begin
                    for (int i = 0; i < table_count; i++)
                        if (hit < 0 && table_keys[i] == acct)
                            hit = i;
                    if (hit >= 0)
                    begin
                        r.status   = skt_pkg::STAT_DUP;
                        r.position = hit[skt_pkg::POS_W-1:0];
                    end
                    else
                    begin
                        // The new record goes in front of the first larger
                        // key, and everything from there on moves up a slot.
                        slot = table_count;
                        for (int i = table_count - 1; i >= 0; i--)
                            if (table_keys[i] > acct)
                                slot = i;
                        for (int i = table_count; i > slot; i--)
                        begin
                            table_keys[i] = table_keys[i-1];
                            table_deps[i] = table_deps[i-1];
                            table_pins[i] = table_pins[i-1];
                        end
                        table_keys[slot] = acct;
                        table_deps[slot] = dep;
                        table_pins[slot] = pin;
                        table_count++;
                        r.position = slot[skt_pkg::POS_W-1:0];
                    end
                end
            end
            skt_pkg::ACT_LOOKUP:
            begin
                for (int i = 0; i < table_count; i++)
                    if (hit < 0 && table_keys[i] == acct)
                        hit = i;
                if (hit >= 0)
                begin
                    r.position      = hit[skt_pkg::POS_W-1:0];
                    r.found_deposit = table_deps[hit];
                    r.found_pin     = table_pins[hit];
                end
                else
                begin
                    r.status = skt_pkg::STAT_MISSING;
                end
            end
            default:
            begin
                // The spare action code leaves the table alone.
            end
        endcase
        r.entry_count = table_count[skt_pkg::CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic queue_request(
        input logic [skt_pkg::ACTION_W-1:0] act,
        input logic [skt_pkg::KEY_W-1:0]    acct,
        input logic [skt_pkg::DEP_W-1:0]    dep,
        input logic [skt_pkg::PIN_W-1:0]    pin
    );
        request_t item;
        item.act  = act;
        item.acct = acct;
        item.dep  = dep;
        item.pin  = pin;
        item.hold = hold_next;
        hold_next = 1'b0;
        req_q.push_back(item);
    endtask

    function automatic logic [skt_pkg::DEP_W-1:0] rand_dep();
        return skt_pkg::DEP_W'($urandom);
    endfunction

    function automatic logic [skt_pkg::PIN_W-1:0] rand_pin();
        return skt_pkg::PIN_W'({$urandom, $urandom});
    endfunction

    function automatic bit is_live(input logic [skt_pkg::KEY_W-1:0] acct);
        foreach (live_keys[i])
            if (live_keys[i] == acct)
                return 1'b1;
        return 1'b0;
    endfunction

    // Mostly legal account numbers, a dense low pool to provoke collisions,
    // and now and then a value above the five-digit range that the port
    // width still allows.
    function automatic logic [skt_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0, 1, 2: return skt_pkg::KEY_W'($urandom_range(63));
            3:       return skt_pkg::KEY_W'($urandom_range(131071, 100000));
            default: return skt_pkg::KEY_W'($urandom_range(99999));
        endcase
    endfunction

    // A key already in the table with the given chance in percent, else a
    // fresh random one.
    function automatic logic [skt_pkg::KEY_W-1:0] pick_known(input int pct);
        if (live_keys.size() != 0 && $urandom_range(99) < pct)
            return live_keys[$urandom_range(live_keys.size() - 1)];
        return pick_key();
    endfunction

    // Idling plan: the sender idles a third of the time against a receiver
    // that idles most of the time, then the two swap, and the last third
    // runs with neither side idling.
    always_comb
    begin
        if (n_sent < stim_total / 3)
        begin
            send_idle_pct = 33;
            recv_idle_pct = 70;
        end
        else if (n_sent < 2 * stim_total / 3)
        begin
            send_idle_pct = 70;
            recv_idle_pct = 33;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // Driver. The expected result of an item is worked out on the edge that
    // accepts it. The block registers its result, so that expectation is in
    // place before the matching result can show up on a later edge.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        logic     took;
        request_t nxt;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            action    <= skt_pkg::ACT_CLEAR;
            key       <= '0;
            deposit   <= '0;
            pin_value <= '0;
            n_sent    <= 0;
        end
        else
        begin
            took = in_valid && in_ready;
            if (took)
            begin
                owed_q.push_back(predict_request(action, key, deposit, pin_value));
                n_sent <= n_sent + 1;
            end
            // Valid only drops after an acceptance, never while an item waits.
            if (!in_valid || took)
            begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                    !(req_q[0].hold && (n_sent + int'(took) != n_recv)))
                begin
                    nxt = req_q.pop_front();
                    in_valid  <= 1'b1;
                    action    <= nxt.act;
                    key       <= nxt.acct;
                    deposit   <= nxt.dep;
                    pin_value <= nxt.pin;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every accepted result is checked against the oldest
    // expectation; a result with nothing owed is a failure as well.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        skt_pkg::result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            n_recv    <= 0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (out_valid && out_ready)
            begin
                n_recv <= n_recv + 1;
                if (owed_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: st %0d pos %0d cnt %0d",
                                 $time, status, position, entry_count);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (status !== want.status || position !== want.position ||
                        found_deposit !== want.found_deposit ||
                        found_pin !== want.found_pin || entry_count !== want.entry_count)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("%0t: result %0d mismatch", $time, n_recv);
                            $display("  expected st %0d pos %0d dep %h pin %h cnt %0d",
                                     want.status, want.position, want.found_deposit,
                                     want.found_pin, want.entry_count);
                            $display("  got      st %0d pos %0d dep %h pin %h cnt %0d",
                                     status, position, found_deposit, found_pin,
                                     entry_count);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : run_test
        int                        n_ops;
        int                        r;
        int                        mode;
        int                        base;
        int                        step;
        int                        acct_val;
        logic [skt_pkg::KEY_W-1:0] k;

        // Directed opening: edges of every field, each action, the spare
        // action code, misses, a duplicate, front, middle and back inserts,
        // and a clear of an already empty table.
        queue_request(skt_pkg::ACT_LOOKUP, 17'd0, '0, '0);
        queue_request(skt_pkg::ACT_INSERT, 17'd50000, 31'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_request(skt_pkg::ACT_INSERT, 17'd0, '0, '0);
        queue_request(skt_pkg::ACT_INSERT, 17'd99999, rand_dep(), rand_pin());
        queue_request(skt_pkg::ACT_INSERT, 17'h1FFFF, 31'd1, 48'd1);
        queue_request(skt_pkg::ACT_INSERT, 17'd50000, rand_dep(), rand_pin());
        queue_request(skt_pkg::ACT_INSERT, 17'd25000, rand_dep(), rand_pin());
        queue_request(skt_pkg::ACT_LOOKUP, 17'd0, rand_dep(), rand_pin());
        queue_request(skt_pkg::ACT_LOOKUP, 17'h1FFFF, '0, '0);
        queue_request(skt_pkg::ACT_LOOKUP, 17'd50000, '0, '0);
        queue_request(skt_pkg::ACT_LOOKUP, 17'd12345, '0, '0);
        queue_request(skt_pkg::ACT_LOOKUP, 17'd99999, '0, '0);
        queue_request(ACT_SPARE, 17'd50000, 31'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_request(skt_pkg::ACT_INSERT, 17'd1, rand_dep(), rand_pin());
        // The sender waits for every outstanding result before this clear.
        hold_next = 1'b1;
        queue_request(skt_pkg::ACT_CLEAR, 17'h1FFFF, 31'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_request(skt_pkg::ACT_LOOKUP, 17'd50000, '0, '0);
        queue_request(skt_pkg::ACT_CLEAR, '0, '0, '0);
        queue_request(skt_pkg::ACT_INSERT, 17'd70000, rand_dep(), rand_pin());
        queue_request(skt_pkg::ACT_LOOKUP, 17'd70000, '0, '0);
        queue_request(ACT_SPARE, '0, '0, '0);
        queue_request(skt_pkg::ACT_INSERT, 17'd69999, rand_dep(), rand_pin());
        live_keys = '{17'd70000, 17'd69999};

        // Random part, built from sessions. Most sessions mix inserts and
        // lookups on a partly filled table; some fill the table to the top
        // in ascending, descending or random key order and then push on
        // against the full table.
        hold_next = 1'b1;
        stim_total = req_q.size() + RANDOM_ITEMS;
        while (req_q.size() < stim_total)
        begin
            if ($urandom_range(5) == 0)
            begin
                mode = $urandom_range(2);
                step = $urandom_range(1500, 1);
                base = $urandom_range(99999 - TABLE_DEPTH * step);
                hold_next = 1'b1;
                queue_request(skt_pkg::ACT_CLEAR, pick_key(), rand_dep(), rand_pin());
                live_keys.delete();
                for (int j = 0; j < TABLE_DEPTH; j++)
                begin
                    case (mode)
                        0:       acct_val = base + j * step;
                        1:       acct_val = base + (TABLE_DEPTH - 1 - j) * step;
                        default:
                        begin
                            do
                                acct_val = int'(pick_key());
                            while (is_live(acct_val[skt_pkg::KEY_W-1:0]));
                        end
                    endcase
                    k = acct_val[skt_pkg::KEY_W-1:0];
                    live_keys.push_back(k);
                    queue_request(skt_pkg::ACT_INSERT, k, rand_dep(), rand_pin());
                end
                // Against a full table, both a duplicate and a new key.
                queue_request(skt_pkg::ACT_INSERT, pick_known(100), rand_dep(), rand_pin());
                queue_request(skt_pkg::ACT_INSERT, pick_key(), rand_dep(), rand_pin());
                queue_request(skt_pkg::ACT_LOOKUP, live_keys[0], rand_dep(), rand_pin());
                queue_request(skt_pkg::ACT_LOOKUP, live_keys[TABLE_DEPTH-1], '0, '0);
                for (int j = 0; j < 4; j++)
                    queue_request(skt_pkg::ACT_LOOKUP, pick_known(80), rand_dep(), rand_pin());
            end
            else
            begin
                n_ops = $urandom_range(30, 8);
                hold_next = ($urandom_range(3) == 0);
                if ($urandom_range(1) == 1)
                begin
                    queue_request(skt_pkg::ACT_CLEAR, pick_key(), rand_dep(), rand_pin());
                    live_keys.delete();
                end
                for (int j = 0; j < n_ops; j++)
                begin
                    r = $urandom_range(99);
                    if (r < 50)
                    begin
                        k = pick_known(20);
                        if (!is_live(k) && live_keys.size() < TABLE_DEPTH)
                            live_keys.push_back(k);
                        queue_request(skt_pkg::ACT_INSERT, k, rand_dep(), rand_pin());
                    end
                    else if (r < 90)
                    begin
                        queue_request(skt_pkg::ACT_LOOKUP, pick_known(70), rand_dep(),
                                      rand_pin());
                    end
                    else if (r < 95)
                    begin
                        queue_request(ACT_SPARE, pick_key(), rand_dep(), rand_pin());
                    end
                    else
                    begin
                        queue_request(skt_pkg::ACT_CLEAR, pick_key(), rand_dep(), rand_pin());
                        live_keys.delete();
                    end
                end
            end
        end
        stim_total = req_q.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait, sampling between edges, until every item has been taken and
        // every result has come back, or until the watchdog fires.
        forever
        begin
            @(negedge clk);
            if (req_q.size() == 0 && !in_valid && owed_q.size() == 0)
                break;
            if (stall_cycles >= STALL_LIMIT)
            begin
                timed_out = 1'b1;
                break;
            end
        end
        if (!timed_out)
            repeat (TAIL_CYCLES) @(negedge clk);

        if (!timed_out && fail_count == 0 && owed_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
